/* design/smcf_pkg.sv */
// ----------------------------------------------------------------------------
// smcf_pkg
// Shared types and constants for the serial motor command framer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package smcf_pkg;

  // Frame layout
  localparam logic [7:0] START_BYTE  = 8'h2A;  // '*'
  localparam logic [7:0] END_BYTE    = 8'h23;  // '#'
  localparam int         NUM_FIELDS  = 3;
  localparam int         FIELD_CHARS = 5;      // converted bytes per 6-byte slot
  localparam logic [1:0] SLOT_LAST   = 2'd2;
  localparam logic [2:0] OFF_LAST    = 3'd5;   // separator / end byte offset in slot

  // Character codes
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Magnitude handling
  localparam int          DUTY_W    = 17;
  localparam logic [16:0] MAG_LIMIT = 17'd99999;
  localparam logic [16:0] MAG_SAT   = 17'd9999;  // above this, next digit saturates

  // Watchdog
  localparam int          TMO_W   = 16;
  localparam logic [15:0] TMO_RST = 16'd500;
  localparam logic [15:0] IDLE_MAX = 16'hFFFF;

  localparam int OUT_TDATA_W = 64;

  // Field conversion phase
  typedef enum logic [2:0] {
    PH_BLANK = 3'b001,
    PH_CONV  = 3'b010,
    PH_DONE  = 3'b100
  } phase_t;

  // Framer state
  typedef enum logic [1:0] {
    FR_HUNT = 2'b01,
    FR_BODY = 2'b10
  } frame_t;

  typedef struct packed {
    logic [DUTY_W-1:0] mag;
    logic              neg;
  } fld_res_t;

  typedef struct packed {
    logic expired_nxt;  // flag value after this step
    logic force_zero;   // idle time has passed the timeout on this tick
    logic abort;        // flag is rising: drop any frame in progress
  } wd_stat_t;

endpackage

/* design/smcf_field.sv */
// ----------------------------------------------------------------------------
// smcf_field
// One decimal field converter: skips blanks, reads a sign, accumulates
// digits with saturation at 99999.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smcf_field (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clear,   // start of a new frame
  input  logic              feed,    // byte belongs to this field
  input  logic [7:0]        ch,
  output smcf_pkg::fld_res_t res
);
  import smcf_pkg::*;

  logic [DUTY_W-1:0] val_r, val_nxt;
  logic              neg_r, neg_nxt;
  phase_t            ph_r, ph_nxt;

  logic              is_blank, is_digit, is_sign;
  logic [DUTY_W-1:0] acc;

  // Character classes
  assign is_blank = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);

  // value * 10 + digit, saturating
  always_comb begin
    if (val_r > MAG_SAT) begin
      acc = MAG_LIMIT;
    end else begin
      acc = (val_r << 3) + (val_r << 1) + DUTY_W'(ch - CH_ZERO);
    end
  end

  // Conversion step
  always_comb begin
    val_nxt = val_r;
    neg_nxt = neg_r;
    ph_nxt  = ph_r;
    if (clear) begin
      val_nxt = '0;
      neg_nxt = 1'b0;
      ph_nxt  = PH_BLANK;
    end else if (feed) begin
      case (ph_r)
        PH_BLANK: begin
          if (is_sign) begin
            neg_nxt = (ch == CH_MINUS);
            ph_nxt  = PH_CONV;
          end else if (is_digit) begin
            val_nxt = acc;
            ph_nxt  = PH_CONV;
          end else if (!is_blank) begin
            ph_nxt = PH_DONE;
          end
        end
        PH_CONV: begin
          if (is_digit) begin
            val_nxt = acc;
          end else begin
            ph_nxt = PH_DONE;
          end
        end
        PH_DONE: ph_nxt = PH_DONE;
        default: ph_nxt = PH_DONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
      neg_r <= 1'b0;
      ph_r  <= PH_BLANK;
    end else begin
      val_r <= val_nxt;
      neg_r <= neg_nxt;
      ph_r  <= ph_nxt;
    end
  end

  assign res.mag = val_r;
  assign res.neg = neg_r;

endmodule

/* design/smcf_watchdog.sv */
// ----------------------------------------------------------------------------
// smcf_watchdog
// Idle tick counter with programmable timeout and expired flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smcf_watchdog (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [smcf_pkg::TMO_W-1:0] cfg_tmo,
  input  logic                       tick,   // millisecond tick processed
  input  logic                       kick,   // valid frame committed
  output smcf_pkg::wd_stat_t         stat
);
  import smcf_pkg::*;

  logic [TMO_W-1:0] tmo_r;
  logic [TMO_W-1:0] idle_r, idle_nxt, idle_inc;
  logic             exp_r, exp_nxt;
  logic             over;

  // Saturating increment and timeout compare
  assign idle_inc = (idle_r == IDLE_MAX) ? idle_r : idle_r + 1'b1;
  assign over     = tick && (idle_inc > tmo_r);

  always_comb begin
    idle_nxt = idle_r;
    exp_nxt  = exp_r;
    if (kick) begin
      idle_nxt = '0;
      exp_nxt  = 1'b0;
    end else if (tick) begin
      idle_nxt = idle_inc;
      if (over) begin
        exp_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmo_r  <= TMO_RST;
      idle_r <= '0;
      exp_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        tmo_r <= cfg_tmo;
      end
      idle_r <= idle_nxt;
      exp_r  <= exp_nxt;
    end
  end

  assign stat.expired_nxt = exp_nxt;
  assign stat.force_zero  = over;
  assign stat.abort       = over && !exp_r;

endmodule

/* design/serial_motor_command_framer.sv */
// ----------------------------------------------------------------------------
// serial_motor_command_framer
// Frames '*'-started, '#'-terminated serial commands carrying three signed
// decimal speeds and drives magnitude / direction for three motors, with an
// idle watchdog that zeroes all speeds.
// ----------------------------------------------------------------------------
// Pipeline: an input transfer is captured in the input register, and its result
//   is written to the result register that drives out_tdata.
// Throughput: one item per cycle while the result register is not stalled; the input
//   register feeds one pass of framing, field conversion and watchdog logic.
// Reset (rst_n low, synchronous): hunting for '*', speeds zero, idle timer
//   and expired flag clear, timeout 500; both pipeline stages empty.
`timescale 1ns / 1ps

module serial_motor_command_framer (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: timeout_ms
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] action (0 byte, 1 tick)
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // [16:0] duty_a, [17] fwd_a, [18] rev_a,
                                  // [35:19] duty_b, [36] fwd_b, [37] rev_b,
                                  // [54:38] duty_c, [55] fwd_c, [56] rev_c,
                                  // [57] frame_accepted, [58] watchdog_expired,
                                  // [63:59] zero
);
  import smcf_pkg::*;

  // Input register
  logic       s1_vld_r;
  logic [7:0] s1_byte_r;
  logic       s1_tick_r;
  logic       in_xfer, adv, proc;

  // Framer state
  frame_t     fr_r, fr_nxt;
  logic [1:0] slot_r, slot_nxt;
  logic [2:0] off_r, off_nxt;

  // Committed speeds
  logic [DUTY_W-1:0] spd_mag_r [NUM_FIELDS];
  logic [DUTY_W-1:0] spd_mag_nxt [NUM_FIELDS];
  logic              spd_neg_r [NUM_FIELDS];
  logic              spd_neg_nxt [NUM_FIELDS];

  // Result register
  logic                   out_vld_r;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic     is_byte, is_end, start, commit, feed_ok;
  fld_res_t fres [NUM_FIELDS];
  wd_stat_t wd;

  // Handshakes
  assign cfg_ready = 1'b1;
  assign adv       = !out_vld_r || out_tready;
  assign in_tready = !s1_vld_r || adv;
  assign in_xfer   = in_tvalid && in_tready;
  assign proc      = s1_vld_r && adv;

  // Byte classification for the framer
  assign is_byte = proc && !s1_tick_r;
  assign is_end  = (slot_r == SLOT_LAST) && (off_r == OFF_LAST);
  assign start   = is_byte && (fr_r == FR_HUNT) && (s1_byte_r == START_BYTE);
  assign commit  = is_byte && (fr_r == FR_BODY) && is_end && (s1_byte_r == END_BYTE);
  assign feed_ok = is_byte && (fr_r == FR_BODY) && !is_end && (off_r < 3'(FIELD_CHARS));

  // Field converters
  for (genvar k = 0; k < NUM_FIELDS; k++) begin : g_fld
    smcf_field u_fld (
      .clk   (clk),
      .rst_n (rst_n),
      .clear (start),
      .feed  (feed_ok && (slot_r == 2'(k))),
      .ch    (s1_byte_r),
      .res   (fres[k])
    );
  end

  smcf_watchdog u_wd (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_we  (cfg_valid && cfg_ready),
    .cfg_tmo (cfg_data),
    .tick    (proc && s1_tick_r),
    .kick    (commit),
    .stat    (wd)
  );

  // Frame position tracking
  always_comb begin
    fr_nxt   = fr_r;
    slot_nxt = slot_r;
    off_nxt  = off_r;
    if (start) begin
      fr_nxt   = FR_BODY;
      slot_nxt = '0;
      off_nxt  = '0;
    end else if (is_byte && (fr_r == FR_BODY)) begin
      if (is_end) begin
        fr_nxt = FR_HUNT;
      end else if (off_r == OFF_LAST) begin
        off_nxt  = '0;
        slot_nxt = slot_r + 1'b1;
      end else begin
        off_nxt = off_r + 1'b1;
      end
    end else if (wd.abort) begin
      fr_nxt = FR_HUNT;
    end
  end

  // Speed commit / watchdog zeroing and result packing
  always_comb begin
    out_data_nxt = '0;
    for (int k = 0; k < NUM_FIELDS; k++) begin
      spd_mag_nxt[k] = spd_mag_r[k];
      spd_neg_nxt[k] = spd_neg_r[k];
      if (commit) begin
        spd_mag_nxt[k] = fres[k].mag;
        spd_neg_nxt[k] = fres[k].neg;
      end else if (wd.force_zero) begin
        spd_mag_nxt[k] = '0;
        spd_neg_nxt[k] = 1'b0;
      end
      out_data_nxt[k*(DUTY_W+2) +: DUTY_W] = spd_mag_nxt[k];
      out_data_nxt[k*(DUTY_W+2) + DUTY_W]  = (spd_mag_nxt[k] != '0) && !spd_neg_nxt[k];
      out_data_nxt[k*(DUTY_W+2) + DUTY_W + 1] = (spd_mag_nxt[k] != '0) && spd_neg_nxt[k];
    end
    out_data_nxt[NUM_FIELDS*(DUTY_W+2)]     = commit;
    out_data_nxt[NUM_FIELDS*(DUTY_W+2) + 1] = wd.expired_nxt;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      fr_r      <= FR_HUNT;
      slot_r    <= '0;
      off_r     <= '0;
      for (int k = 0; k < NUM_FIELDS; k++) begin
        spd_mag_r[k] <= '0;
        spd_neg_r[k] <= 1'b0;
      end
    end else begin
      if (in_xfer) begin
        s1_vld_r <= 1'b1;
      end else if (adv) begin
        s1_vld_r <= 1'b0;
      end
      if (proc) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
      fr_r   <= fr_nxt;
      slot_r <= slot_nxt;
      off_r  <= off_nxt;
      for (int k = 0; k < NUM_FIELDS; k++) begin
        spd_mag_r[k] <= spd_mag_nxt[k];
        spd_neg_r[k] <= spd_neg_nxt[k];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte_r <= in_tdata;
      s1_tick_r <= in_tuser;
    end
    if (proc) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

/* design/smcf_checker.sv */
// ----------------------------------------------------------------------------
// smcf_checker
// Port-level checks on the motor command framer's result stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smcf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata
);

  // Direction bits are exclusive; for motor a they are only set with a non-zero magnitude
  a_dir_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      !(out_tdata[17] && out_tdata[18]) && !(out_tdata[36] && out_tdata[37]) &&
      !(out_tdata[55] && out_tdata[56]) &&
      ((out_tdata[16:0] != 17'd0) || (!out_tdata[17] && !out_tdata[18])))
    else $error("direction bits inconsistent");

  // While expired, all speeds are held at zero
  a_exp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[58]) |->
      (out_tdata[16:0] == 17'd0) && (out_tdata[35:19] == 17'd0) &&
      (out_tdata[54:38] == 17'd0))
    else $error("speed non-zero while watchdog expired");

  // An accepted frame always clears the expired flag
  a_acc_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[57]) |-> !out_tdata[58])
    else $error("frame accepted with watchdog still expired");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

endmodule

bind serial_motor_command_framer smcf_checker u_smcf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
